// File: rtl/core/mabs_pkg.sv
// ----------------------------------------------------------------------------
// mabs_pkg
// Shared types and constants of the multi-axis Bresenham step generator.
// ----------------------------------------------------------------------------
package mabs_pkg;

    localparam int STEP_W  = 31;
    localparam int POS_W   = 32;
    localparam int ERR_W   = 33;
    localparam int IN_AXES = 4;

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_TICK  = 2'd1,
        OP_SETPOS = 2'd2,
        OP_ABORT = 2'd3
    } mabs_op_t;

    typedef struct packed {
        logic load;
        logic tick;
        logic set_pos;
    } mabs_axis_ctrl_t;

endpackage

// File: rtl/core/mabs_axis.sv
// ----------------------------------------------------------------------------
// mabs_axis
// One axis: error counter, step count, direction and step position.
// ----------------------------------------------------------------------------
module mabs_axis
    import mabs_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  mabs_axis_ctrl_t         ctrl,
    input  logic [STEP_W-1:0]       steps_load,
    input  logic                    dir_load,
    input  logic [ERR_W-1:0]        err_start,
    input  logic [STEP_W-1:0]       total_events,
    input  logic [POS_W-1:0]        pos_load,
    output logic                    pulse,
    output logic [POS_W-1:0]        pos_next
);

    logic [ERR_W-1:0]  err_reg;
    logic [ERR_W-1:0]  err_next;
    logic [STEP_W-1:0] steps_reg;
    logic              dir_reg;
    logic [POS_W-1:0]  pos_reg;
    logic [ERR_W-1:0]  err_sum;

    assign err_sum = err_reg + {{(ERR_W-STEP_W){1'b0}}, steps_reg};
    assign pulse   = ctrl.tick && !err_sum[ERR_W-1] && (err_sum != '0);

    always_comb
    begin
        err_next = err_reg;
        pos_next = pos_reg;
        if (ctrl.load)
        begin
            err_next = err_start;
        end
        else if (ctrl.tick)
        begin
            err_next = err_sum;
            if (pulse)
            begin
                err_next = err_sum - {{(ERR_W-STEP_W){1'b0}}, total_events};
                pos_next = dir_reg ? pos_reg - POS_W'(1) : pos_reg + POS_W'(1);
            end
        end
        else if (ctrl.set_pos)
        begin
            pos_next = pos_load;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            err_reg   <= '0;
            steps_reg <= '0;
            dir_reg   <= 1'b0;
            pos_reg   <= '0;
        end
        else
        begin
            err_reg <= err_next;
            pos_reg <= pos_next;
            if (ctrl.load)
            begin
                steps_reg <= steps_load;
                dir_reg   <= dir_load;
            end
        end
    end

endmodule

// File: rtl/core/multi_axis_bresenham_stepper.sv
// ----------------------------------------------------------------------------
// multi_axis_bresenham_stepper
// Bresenham step distributor over several axes with load, tick, set-position
// and abort operations; one result beat for every input beat.
// ----------------------------------------------------------------------------
// An accepted input beat passes the input register and then the result register.
// Throughput is one beat per cycle while m_tready does not stall the result register;
// the per-axis add, compare and subtract lie between the input register and the result register.
// Reset clears all positions, counters, step counts and the active flag.
// ----------------------------------------------------------------------------
module multi_axis_bresenham_stepper
    import mabs_pkg::*;
#(
    parameter int AXES = 4
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // steps_x, steps_y, steps_z, steps_e, event_count, dir_bits, axis_sel,
    // position_value, zero fill
    input  logic [199:0] s_tdata,
    // op
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // step_mask, active, pos_x, pos_y, pos_z, pos_e, zero fill
    output logic [135:0] m_tdata,
    output logic         m_tlast
);

    logic                              in_valid_reg;
    mabs_op_t                          op_reg;
    logic [IN_AXES-1:0][STEP_W-1:0]    steps_reg;
    logic [STEP_W-1:0]                 event_reg;
    logic [IN_AXES-1:0]                dir_reg;
    logic [1:0]                        sel_reg;
    logic [POS_W-1:0]                  posval_reg;

    logic                              out_valid_reg;
    logic [IN_AXES-1:0]                mask_reg;
    logic                              done_reg;
    logic [IN_AXES-1:0][POS_W-1:0]     pos_out_reg;

    logic [STEP_W-1:0]                 total_reg;
    logic [STEP_W-1:0]                 done_cnt_reg;
    logic [STEP_W-1:0]                 done_cnt_next;
    logic                              active_reg;
    logic                              active_next;

    logic                              advance;
    logic                              tick;
    logic                              finish;
    logic [ERR_W-1:0]                  err_start;
    logic [AXES-1:0]                   pulse;
    logic [AXES-1:0][POS_W-1:0]        pos_next;
    logic [IN_AXES-1:0]                mask_next;
    logic [IN_AXES-1:0][POS_W-1:0]     pos_out_next;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            op_reg       <= mabs_op_t'(s_tuser);
            steps_reg[0] <= s_tdata[30:0];
            steps_reg[1] <= s_tdata[61:31];
            steps_reg[2] <= s_tdata[92:62];
            steps_reg[3] <= s_tdata[123:93];
            event_reg    <= s_tdata[154:124];
            dir_reg      <= s_tdata[158:155];
            sel_reg      <= s_tdata[160:159];
            posval_reg   <= s_tdata[192:161];
        end
    end

    assign tick          = advance && (op_reg == OP_TICK) && active_reg;
    assign done_cnt_next = done_cnt_reg + STEP_W'(1);
    assign finish        = tick && (done_cnt_next >= total_reg);
    assign err_start     = ERR_W'(0) - {{(ERR_W-STEP_W+1){1'b0}}, event_reg[STEP_W-1:1]};

    always_comb
    begin
        active_next = active_reg;
        if (advance)
        begin
            unique case (op_reg)
                OP_LOAD:   active_next = 1'b1;
                OP_TICK:   active_next = active_reg && !finish;
                OP_SETPOS: active_next = active_reg;
                OP_ABORT:  active_next = 1'b0;
                default:   active_next = active_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg    <= '0;
            done_cnt_reg <= '0;
            active_reg   <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
            if (advance && (op_reg == OP_LOAD))
            begin
                total_reg    <= event_reg;
                done_cnt_reg <= '0;
            end
            else if (tick)
            begin
                done_cnt_reg <= done_cnt_next;
            end
        end
    end

    for (genvar i = 0; i < AXES; i++)
    begin : g_axis
        mabs_axis_ctrl_t   ctrl;
        logic [STEP_W-1:0] steps_in;
        logic              dir_in;

        if (i < IN_AXES)
        begin : g_in
            assign steps_in = steps_reg[i];
            assign dir_in   = dir_reg[i];
        end
        else
        begin : g_pad
            assign steps_in = '0;
            assign dir_in   = 1'b0;
        end

        assign ctrl.load    = advance && (op_reg == OP_LOAD);
        assign ctrl.tick    = tick;
        assign ctrl.set_pos = advance && (op_reg == OP_SETPOS) && (int'(sel_reg) == i);

        mabs_axis u_axis
        (
            .clk          (clk),
            .rst_n        (rst_n),
            .ctrl         (ctrl),
            .steps_load   (steps_in),
            .dir_load     (dir_in),
            .err_start    (err_start),
            .total_events (total_reg),
            .pos_load     (posval_reg),
            .pulse        (pulse[i]),
            .pos_next     (pos_next[i])
        );
    end

    for (genvar i = 0; i < IN_AXES; i++)
    begin : g_out
        if (i < AXES)
        begin : g_live
            assign mask_next[i]    = pulse[i];
            assign pos_out_next[i] = pos_next[i];
        end
        else
        begin : g_zero
            assign mask_next[i]    = 1'b0;
            assign pos_out_next[i] = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            mask_reg    <= mask_next;
            done_reg    <= finish;
            pos_out_reg <= pos_out_next;
        end
    end

    logic active_out_reg;

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            active_out_reg <= active_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = done_reg;
    assign m_tdata  = {3'b000, pos_out_reg[3], pos_out_reg[2], pos_out_reg[1],
                       pos_out_reg[0], active_out_reg, mask_reg};

endmodule
